@@ rtl/core/fgmr_pkg.sv @@
// Shared types and constants for the functional graph max reach core.
// Used by the controller, the datapath, the RAM and the top level.
package fgmr_pkg;

   localparam int MAX_NODES_DEF = 4096;
   localparam int NODE_W        = 13;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] successor;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] best_node;
      logic [NODE_W-1:0] reach_count;
   } rsp_type;

   // per-node walk status, stored next to the reach count
   typedef enum logic [1:0] {
      VS_UNVISITED = 2'd0,
      VS_ON_WALK   = 2'd1,
      VS_DONE      = 2'd2
   } visit_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_PUSH,
      ST_SUCC,
      ST_CHK,
      ST_CYC,
      ST_UNWIND,
      ST_DRAIN,
      ST_CLEAR,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLR_STEP,
      OP_SCAN_RD,
      OP_SCAN_NEXT,
      OP_WALK_START,
      OP_PUSH,
      OP_SUCC,
      OP_HIT_DONE,
      OP_HIT_WALK,
      OP_ADVANCE,
      OP_CYC_STEP,
      OP_UNWIND_STEP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic      i_last;
      logic      clr_last;
      logic      init_last;
      logic      nxt_bad;
      visit_type visit;
      logic      top_zero;
      logic      top_one;
      logic      k_last;
   } dp_status_type;

endpackage

@@ rtl/core/fgmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on fgmr_pkg for default sizes only.
module fgmr_ram #(
   parameter int WIDTH = fgmr_pkg::NODE_W,
   parameter int DEPTH = fgmr_pkg::MAX_NODES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fgmr_ctrl.sv @@
// Sequencer for the max reach core: load, scan, walk, unwind, clear, emit.
// Depends on fgmr_pkg; drives fgmr_dp through one op code per cycle.
module fgmr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    item_last,
   input  fgmr_pkg::dp_status_type status,
   output fgmr_pkg::dp_op_type     op,
   output logic                    busy,
   output logic                    rsp_valid
);
   import fgmr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && item_last) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (status.visit == VS_UNVISITED) state_in = ST_PUSH;
            else if (status.i_last) state_in = ST_CLEAR;
            else state_in = ST_SCAN_RD;
         end
         ST_PUSH: state_in = ST_SUCC;
         ST_SUCC: state_in = status.nxt_bad ? ST_UNWIND : ST_CHK;
         ST_CHK: begin
            unique case (status.visit)
               VS_DONE:      state_in = ST_UNWIND;
               VS_ON_WALK:   state_in = ST_CYC;
               VS_UNVISITED: state_in = ST_PUSH;
               default:      state_in = ST_UNWIND;
            endcase
         end
         ST_CYC: begin
            if (status.k_last) state_in = ST_UNWIND;
         end
         ST_UNWIND: begin
            if (status.top_zero || status.top_one) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = status.i_last ? ST_CLEAR : ST_SCAN_RD;
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_EMIT;
         end
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op = OP_NONE;
      unique case (state_ff)
         ST_INIT:     op = OP_CLR_STEP;
         ST_IDLE:     op = start ? OP_LOAD : OP_NONE;
         ST_SCAN_RD:  op = OP_SCAN_RD;
         ST_SCAN_CHK: op = (status.visit == VS_UNVISITED) ? OP_WALK_START : OP_SCAN_NEXT;
         ST_PUSH:     op = OP_PUSH;
         ST_SUCC:     op = OP_SUCC;
         ST_CHK: begin
            unique case (status.visit)
               VS_DONE:      op = OP_HIT_DONE;
               VS_ON_WALK:   op = OP_HIT_WALK;
               VS_UNVISITED: op = OP_ADVANCE;
               default:      op = OP_NONE;
            endcase
         end
         ST_CYC:      op = OP_CYC_STEP;
         ST_UNWIND:   op = status.top_zero ? OP_NONE : OP_UNWIND_STEP;
         ST_DRAIN:    op = OP_SCAN_NEXT;
         ST_CLEAR:    op = OP_CLR_STEP;
         ST_EMIT:     op = OP_FINISH;
         default:     op = OP_NONE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && item_last) |=> busy)
      else $error("closing item did not start the walk");

endmodule

@@ rtl/core/fgmr_dp.sv @@
// Datapath of the max reach core: successor, node and path stack RAMs,
// walk counters and best tracking. Depends on fgmr_pkg and fgmr_ram.
module fgmr_dp #(
   parameter int MAX_NODES = fgmr_pkg::MAX_NODES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fgmr_pkg::dp_op_type     op,
   input  fgmr_pkg::req_type       req,
   output fgmr_pkg::dp_status_type status,
   output fgmr_pkg::rsp_type       rsp
);
   import fgmr_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int NR_W  = CNT_W + 2;
   localparam logic [CNT_W-1:0] N_MAX    = CNT_W'(MAX_NODES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NODES - 1);

   // control state
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic             wb_valid_ff, wb_valid_in;
   // walk state
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] nxt_ff, nxt_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] wb_val_ff, wb_val_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;

   logic [NODE_W-1:0] succ_rd;
   logic [NR_W-1:0]   node_rd;
   logic [IDX_W-1:0]  stack_rd;
   visit_type         rd_visit;
   logic [CNT_W-1:0]  rd_reach;

   logic              node_ok;
   logic [IDX_W-1:0]  node_idx;
   logic [IDX_W-1:0]  nxt_idx;
   logic              nxt_bad;
   logic [CNT_W-1:0]  top_m1;
   logic              better;

   logic              node_wr_en;
   logic [IDX_W-1:0]  node_wr_addr;
   logic [NR_W-1:0]   node_wr_data;
   logic [IDX_W-1:0]  node_rd_addr;
   logic [IDX_W-1:0]  stack_rd_addr;
   logic [CNT_W-1:0]  best_node_full;

   assign rd_visit = visit_type'(node_rd[NR_W-1:CNT_W]);
   assign rd_reach = node_rd[CNT_W-1:0];

   assign node_ok  = (req.node != '0) && (32'(req.node) <= 32'(MAX_NODES));
   assign node_idx = IDX_W'(req.node - NODE_W'(1));
   assign nxt_idx  = IDX_W'(succ_rd - NODE_W'(1));
   assign nxt_bad  = (succ_rd == '0) || (32'(succ_rd) > 32'(loaded_ff));
   assign top_m1   = top_ff - CNT_W'(1);

   // writeback of a settled node: larger count wins, smaller node on ties
   assign better = (wb_val_ff > best_cnt_ff) ||
                   ((wb_val_ff == best_cnt_ff) && (stack_rd < best_idx_ff));

   always_comb begin
      loaded_in   = loaded_ff;
      j_in        = j_ff;
      wb_valid_in = 1'b0;
      i_in        = i_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      top_in      = top_ff;
      base_in     = base_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      wb_val_in   = wb_val_ff;
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      unique case (op)
         OP_LOAD: begin
            if (loaded_ff != N_MAX) loaded_in = loaded_ff + CNT_W'(1);
            if (req.last) begin
               i_in        = '0;
               j_in        = '0;
               best_idx_in = '0;
               best_cnt_in = '0;
            end
         end
         OP_CLR_STEP:   j_in = j_ff + IDX_W'(1);
         OP_SCAN_NEXT:  i_in = i_ff + IDX_W'(1);
         OP_WALK_START: begin
            cur_in = i_ff;
            top_in = '0;
         end
         OP_PUSH:       top_in = top_ff + CNT_W'(1);
         OP_SUCC: begin
            nxt_in  = nxt_idx;
            base_in = '0;
         end
         OP_HIT_DONE:   base_in = rd_reach;
         OP_HIT_WALK: begin
            pos_in  = rd_reach;
            k_in    = rd_reach;
            base_in = top_ff - rd_reach;
         end
         OP_ADVANCE:    cur_in = nxt_ff;
         OP_CYC_STEP: begin
            k_in        = k_ff + CNT_W'(1);
            wb_valid_in = 1'b1;
            wb_val_in   = base_ff;
            if (status.k_last) top_in = pos_ff;
         end
         OP_UNWIND_STEP: begin
            top_in      = top_m1;
            base_in     = base_ff + CNT_W'(1);
            wb_valid_in = 1'b1;
            wb_val_in   = base_ff + CNT_W'(1);
         end
         OP_FINISH:     loaded_in = '0;
         default: ;
      endcase
      if (wb_valid_ff && better) begin
         best_idx_in = stack_rd;
         best_cnt_in = wb_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         j_ff        <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         j_ff        <= j_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      top_ff      <= top_in;
      base_ff     <= base_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      wb_val_ff   <= wb_val_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
   end

   // node RAM port mux: writeback, push, clear sweep
   always_comb begin
      node_wr_en = wb_valid_ff || (op == OP_PUSH) || (op == OP_CLR_STEP);
      priority if (wb_valid_ff) begin
         node_wr_addr = stack_rd;
         node_wr_data = {VS_DONE, wb_val_ff};
      end else if (op == OP_PUSH) begin
         node_wr_addr = cur_ff;
         node_wr_data = {VS_ON_WALK, top_ff};
      end else begin
         node_wr_addr = j_ff;
         node_wr_data = {VS_UNVISITED, CNT_W'(0)};
      end
   end

   assign node_rd_addr  = (op == OP_SUCC) ? nxt_idx : i_ff;
   assign stack_rd_addr = (op == OP_CYC_STEP) ? k_ff[IDX_W-1:0] : top_m1[IDX_W-1:0];

   fgmr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_succ_ram (
      .clock   (clock),
      .wr_en   ((op == OP_LOAD) && node_ok),
      .wr_addr (node_idx),
      .wr_data (req.successor),
      .rd_en   (op == OP_PUSH),
      .rd_addr (cur_ff),
      .rd_data (succ_rd)
   );

   fgmr_ram #(.WIDTH(NR_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   ((op == OP_SCAN_RD) || (op == OP_SUCC)),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd)
   );

   fgmr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (op == OP_PUSH),
      .wr_addr (top_ff[IDX_W-1:0]),
      .wr_data (cur_ff),
      .rd_en   ((op == OP_CYC_STEP) || (op == OP_UNWIND_STEP)),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   always_comb begin
      status.i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == loaded_ff;
      status.clr_last  = (CNT_W'(j_ff) + CNT_W'(1)) == loaded_ff;
      status.init_last = (j_ff == IDX_LAST);
      status.nxt_bad   = nxt_bad;
      status.visit     = rd_visit;
      status.top_zero  = (top_ff == '0);
      status.top_one   = (top_ff == CNT_W'(1));
      status.k_last    = (k_ff + CNT_W'(1)) == top_ff;
   end

   assign best_node_full  = CNT_W'(best_idx_ff) + CNT_W'(1);
   assign rsp.best_node   = NODE_W'(best_node_full);
   assign rsp.reach_count = NODE_W'(best_cnt_ff);

   a_stack_room: assert property (@(posedge clock) disable iff (reset)
      (op == OP_PUSH) |-> (top_ff < loaded_ff))
      else $error("path stack overrun");

   a_cycle_on_stack: assert property (@(posedge clock) disable iff (reset)
      (op == OP_HIT_WALK) |-> (rd_reach < top_ff))
      else $error("cycle entry not on the path stack");

   a_wb_count: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> ((wb_val_ff != '0) && (wb_val_ff <= loaded_ff)))
      else $error("settled reach count out of range");

endmodule

@@ rtl/core/functional_graph_max_reach_core.sv @@
// Top level of the functional graph max reach core.
// Depends on fgmr_pkg, fgmr_ctrl, fgmr_dp (which holds the fgmr_ram instances).
//   Input channel: req_data (node, successor, last) is taken at a clock edge
//   with start high and busy low; one edge (node -> successor) per item. The
//   item with last set closes the graph; the item count n gives nodes 1..n.
//   Loading runs at one item per cycle: busy stays low between items.
//   After the closing item busy rises and the core walks the graph:
//     - scan of every start node,
//     - forward walk over each newly visited node, paced by the read
//       latency of the successor and node-status RAMs,
//     - cycle marking / unwind of each node on the walk,
//     - clear of the first n entries of the node-status RAM, then the result.
//   Result channel: rsp_valid is a one-cycle strobe with rsp_data holding
//   the smallest node with the largest reach and its reach count. The
//   receiver cannot stall; rsp_data holds until the next closing item.
//   Reset: synchronous, active high. After reset the core sweeps all
//   MAX_NODES entries of the node-status RAM, with busy high, before it
//   takes the first item.
module functional_graph_max_reach_core #(
   parameter int MAX_NODES = fgmr_pkg::MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fgmr_pkg::req_type req_data,
   output logic              rsp_valid,
   output fgmr_pkg::rsp_type rsp_data
);
   import fgmr_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // sequencer: one datapath op per cycle
   fgmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item_last (req_data.last),
      .status    (status),
      .op        (op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // RAMs, walk counters, best node/count registers
   fgmr_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .req    (req_data),
      .status (status),
      .rsp    (rsp_data)
   );

endmodule
